// ===== design/max_covering_sketch_core_defines.svh =====
// ============================================================================
// max_covering_sketch_core_defines: assertion macros
// Concurrent assertion shorthands clocked on aclk, idle during reset.
// ============================================================================
`ifndef MAX_COVERING_SKETCH_CORE_DEFINES_SVH
`define MAX_COVERING_SKETCH_CORE_DEFINES_SVH

// Same-cycle implication.
`define MCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mcs_pkg.sv =====
// ============================================================================
// mcs_pkg: shared types and constants of the max covering sketch
// Field widths, request codes, lane control and the cell limit helper.
// ============================================================================
package mcs_pkg;

    localparam int IDX_W       = 10;
    localparam int VALUE_W     = 16;
    localparam int RESULT_W    = 17;
    localparam int MAX_ROWS    = 4;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 24;

    localparam int ROWS_DEF       = 4;
    localparam int COLUMNS_DEF    = 1024;
    localparam int COUNT_BITS_DEF = 16;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_QUERY  = 1'b1
    } req_type_t;

    // Per-cycle commands from the sequencer to every lane.
    typedef struct packed {
        logic load;   // capture column index, start reduction
        logic read;   // read the bank at the reduced column
        logic write;  // write back the updated cell
        logic clear;  // zero one column during the reset sweep
    } lane_ctrl_t;

    // Largest magnitude a cell holds: (1 << b) - 1.
    function automatic logic [63:0] cell_max(input int b);
        cell_max = (64'd1 << b) - 64'd1;
    endfunction

endpackage

// ===== design/mcs_lane.sv =====
// ============================================================================
// mcs_lane: one row of the sketch
// Reduces the column index, reads and updates one signed cell per request.
// ============================================================================
module mcs_lane #(
    parameter int COLUMNS    = mcs_pkg::COLUMNS_DEF,
    parameter int COUNT_BITS = mcs_pkg::COUNT_BITS_DEF,
    parameter int COL_W      = $clog2(COLUMNS),
    parameter int CW         = COUNT_BITS + 1
) (
    input  logic                     aclk,
    input  mcs_pkg::lane_ctrl_t      ctrl,
    input  logic [mcs_pkg::IDX_W-1:0] idx,
    input  logic [COUNT_BITS-1:0]    num,
    input  logic [COL_W-1:0]         clr_addr,
    output logic signed [CW-1:0]     cell_val,
    output logic [CW-1:0]            cell_mag,
    output logic                     cell_empty
);
    import mcs_pkg::*;

    // Index modulo COLUMNS by reciprocal multiply, exact for 10-bit indices.
    localparam int RECIP_SHIFT = 22;
    localparam int unsigned RECIP = ((32'd1 << RECIP_SHIFT) + COLUMNS - 1) / COLUMNS;

    logic [CW-1:0]        mem [COLUMNS];
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     quot_reg;
    logic [COL_W-1:0]     addr_reg;
    logic signed [CW-1:0] rd_reg;

    logic [31:0]          quot_prod;
    logic [COL_W-1:0]     addr_comb;
    logic [CW-1:0]        num_ext;
    logic signed [CW-1:0] cell_new;

    always_comb begin
        quot_prod = 32'(quot_reg) * 32'(COLUMNS);
        addr_comb = COL_W'(32'(idx_reg) - quot_prod);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            idx_reg  <= idx;
            quot_reg <= IDX_W'((32'(idx) * 32'(RECIP)) >> RECIP_SHIFT);
        end
        if (ctrl.read) begin
            addr_reg <= addr_comb;
            rd_reg   <= mem[addr_comb];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            mem[clr_addr] <= '0;
        end else if (ctrl.write) begin
            mem[addr_reg] <= cell_new;
        end
    end

    always_comb begin
        cell_val   = rd_reg;
        cell_mag   = rd_reg[CW-1] ? CW'(-rd_reg) : CW'(rd_reg);
        cell_empty = (cell_mag == '0);
        num_ext    = CW'(num);
        // Empty takes the value, smaller takes it flagged, else flag the cell.
        if (cell_empty) begin
            cell_new = num_ext;
        end else if (cell_mag < num_ext) begin
            cell_new = -num_ext;
        end else if (!rd_reg[CW-1]) begin
            cell_new = -rd_reg;
        end else begin
            cell_new = rd_reg;
        end
    end

endmodule

// ===== design/mcs_merge.sv =====
// ============================================================================
// mcs_merge: combine the row cells of one request
// Query: minimum magnitude walk with early stop; insert: any empty row.
// ============================================================================
module mcs_merge #(
    parameter int ROWS       = mcs_pkg::ROWS_DEF,
    parameter int COUNT_BITS = mcs_pkg::COUNT_BITS_DEF,
    parameter int CW         = COUNT_BITS + 1
) (
    input  logic                         is_query,
    input  logic signed [CW-1:0]         cell_val [ROWS],
    input  logic [CW-1:0]                cell_mag [ROWS],
    input  logic [ROWS-1:0]              cell_empty,
    output logic [mcs_pkg::RESULT_W-1:0] query_result,
    output logic                         insert_fresh
);
    import mcs_pkg::*;

    localparam logic [CW-1:0] BEST_INIT = CW'(cell_max(COUNT_BITS) + 64'd1);

    logic [CW-1:0]        best;
    logic signed [CW-1:0] res;
    logic                 done;

    always_comb begin
        best = BEST_INIT;
        res  = '0;
        done = 1'b0;
        for (int r = 0; r < ROWS; r++) begin
            if (!done) begin
                if (cell_mag[r] < best) begin
                    best = cell_mag[r];
                    res  = cell_val[r];
                end else if (!cell_val[r][CW-1] && cell_val[r] != '0) begin
                    // unflagged and not smaller: take it and stop
                    res  = cell_val[r];
                    done = 1'b1;
                end
            end
        end
        query_result = is_query ? RESULT_W'(64'(res)) : '0;
        insert_fresh = !is_query && (|cell_empty);
    end

endmodule

// ===== design/max_covering_sketch_core.sv =====
// ============================================================================
// max_covering_sketch_core: count-min style sketch with max update
// Path: index registers, bank read register, result hold, output register.
// One request at a time (accept, bank read, write back, output load);
// while the output stalls, the next request waits as the core holds in S_OUT.
// Reset: synchronous, active low; then a sweep zeroes every bank, one
// column of all rows per cycle, with s_tready low.
// ============================================================================
`include "max_covering_sketch_core_defines.svh"

module max_covering_sketch_core #(
    parameter int ROWS       = mcs_pkg::ROWS_DEF,
    parameter int COLUMNS    = mcs_pkg::COLUMNS_DEF,
    parameter int COUNT_BITS = mcs_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // row0_index[9:0], row1_index[19:10], row2_index[29:20],
    // row3_index[39:30], count_value[55:40]
    input  logic [mcs_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type: 0 insert, 1 query
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // query_result[16:0], insert_fresh[17], zero pad [23:18]
    output logic [mcs_pkg::M_TDATA_W-1:0] m_tdata
);
    import mcs_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam int CW    = COUNT_BITS + 1;
    localparam logic [COL_W-1:0] CLR_LAST = COL_W'(COLUMNS - 1);
    localparam int VALUE_LSB = MAX_ROWS * IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_MERGE,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic                   clearing_reg, clearing_next;
    logic [COL_W-1:0]       clr_addr_reg, clr_addr_next;
    logic                   is_query_reg, is_query_next;
    logic [COUNT_BITS-1:0]  num_reg, num_next;
    logic [M_TDATA_W-1:0]   result_hold_reg, result_hold_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                   accept;
    lane_ctrl_t             lane_ctrl;
    logic [VALUE_W-1:0]     count_value;
    logic signed [CW-1:0]   lane_cell [ROWS];
    logic [CW-1:0]          lane_mag [ROWS];
    logic [ROWS-1:0]        lane_empty;
    logic [RESULT_W-1:0]    merge_result;
    logic                   merge_fresh;

    assign s_tready    = (state_reg == S_IDLE) && !clearing_reg;
    assign accept      = s_tvalid && s_tready;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign count_value = s_tdata[VALUE_LSB +: VALUE_W];

    // Lane commands: every row steps in lockstep.
    always_comb begin
        lane_ctrl.load  = accept;
        lane_ctrl.read  = (state_reg == S_ADDR);
        lane_ctrl.write = (state_reg == S_MERGE) && !is_query_reg;
        lane_ctrl.clear = clearing_reg;
    end

    for (genvar r = 0; r < ROWS; r++) begin : g_lane
        mcs_lane #(
            .COLUMNS    (COLUMNS),
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .aclk       (aclk),
            .ctrl       (lane_ctrl),
            .idx        (s_tdata[r*IDX_W +: IDX_W]),
            .num        (num_reg),
            .clr_addr   (clr_addr_reg),
            .cell_val   (lane_cell[r]),
            .cell_mag   (lane_mag[r]),
            .cell_empty (lane_empty[r])
        );
    end

    mcs_merge #(
        .ROWS       (ROWS),
        .COUNT_BITS (COUNT_BITS)
    ) u_merge (
        .is_query     (is_query_reg),
        .cell_val     (lane_cell),
        .cell_mag     (lane_mag),
        .cell_empty   (lane_empty),
        .query_result (merge_result),
        .insert_fresh (merge_fresh)
    );

    always_comb begin
        state_next       = state_reg;
        clearing_next    = clearing_reg;
        clr_addr_next    = clr_addr_reg;
        is_query_next    = is_query_reg;
        num_next         = num_reg;
        result_hold_next = result_hold_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        // Zero sweep after reset: one column of every bank per cycle.
        if (clearing_reg) begin
            if (clr_addr_reg == CLR_LAST) begin
                clearing_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    is_query_next = (s_tuser == REQ_QUERY);
                    // saturate the request value to the cell range
                    if (64'(count_value) > cell_max(COUNT_BITS)) begin
                        num_next = COUNT_BITS'(cell_max(COUNT_BITS));
                    end else begin
                        num_next = COUNT_BITS'(count_value);
                    end
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                state_next = S_MERGE;
            end
            S_MERGE: begin
                result_hold_next = M_TDATA_W'({merge_fresh, merge_result});
                state_next       = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = result_hold_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        is_query_reg    <= is_query_next;
        num_reg         <= num_next;
        result_hold_reg <= result_hold_next;
        m_tdata_reg     <= m_tdata_next;
    end

    `MCS_ASSERT_NEXT(a_accept_reads, s_tvalid && s_tready, state_reg == S_ADDR, "accepted request did not move to the bank read")
    `MCS_ASSERT_NOW(a_clear_idle, clearing_reg, state_reg == S_IDLE, "request in flight during the zero sweep")
    `MCS_ASSERT_NOW(a_clear_full, $fell(clearing_reg), $past(clr_addr_reg) == CLR_LAST, "zero sweep ended before the last column")
    `MCS_ASSERT_NEXT(a_insert_zero, state_reg == S_MERGE && !is_query_reg, result_hold_reg[RESULT_W-1:0] == '0, "insert result carries a nonzero query field")
    `MCS_ASSERT_NEXT(a_query_stale, state_reg == S_MERGE && is_query_reg, !result_hold_reg[RESULT_W], "query result marked fresh")

endmodule

// ===== tb/sv/max_covering_sketch_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// max_covering_sketch_core_tb: self-checking bench for the covering sketch
// Drives insert and query requests over the stream input and mirrors the
// cell store in a small class. Each result is checked in order against the
// mirror. Both sides idle and stall at random, with some calm stretches.
// ============================================================================
module max_covering_sketch_core_tb;
    import mcs_pkg::*;

    localparam int ROWS       = ROWS_DEF;
    localparam int COLUMNS    = COLUMNS_DEF;
    localparam int COUNT_BITS = COUNT_BITS_DEF;
    localparam int CELL_LIMIT = (1 << COUNT_BITS) - 1;
    localparam int POOL_SIZE  = 24;
    localparam int RANDOM_REQUESTS = 1500;

    typedef logic [MAX_ROWS-1:0][IDX_W-1:0] sketch_key_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] query_result;
        logic                       insert_fresh;
    } sketch_answer_t;

    // Mirror of the cell store; predicts one answer per accepted request.
    class sketch_mirror;
        logic signed [RESULT_W-1:0] cells [ROWS][COLUMNS];
        sketch_answer_t             awaited_answers[$];
        int                         mismatch_count;

        function new();
            foreach (cells[r, c]) cells[r][c] = '0;
            mismatch_count = 0;
        endfunction

        function int cell_magnitude(input int cval);
            return (cval < 0) ? -cval : cval;
        endfunction

        function void apply_request(input req_type_t kind, input sketch_key_t key,
                                    input logic [VALUE_W-1:0] value);
            sketch_answer_t ans;
            int             num;
            int             cval;
            int             mag;
            int             best;
            int             found;
            int             col;
            ans = '0;
            if (kind == REQ_INSERT) begin
                // saturate to the cell range
                num = (int'(value) > CELL_LIMIT) ? CELL_LIMIT : int'(value);
                for (int r = 0; r < ROWS; r++) begin
                    col  = int'(key[r]) % COLUMNS;
                    cval = cells[r][col];
                    mag  = cell_magnitude(cval);
                    if (mag == 0) begin
                        cells[r][col] = RESULT_W'(num);
                        ans.insert_fresh = 1'b1;
                    end else if (mag < num) begin
                        cells[r][col] = RESULT_W'(-num);
                    end else if (cval > 0) begin
                        cells[r][col] = RESULT_W'(-cval);
                    end
                end
            end else begin
                best  = CELL_LIMIT + 1;
                found = 0;
                for (int r = 0; r < ROWS; r++) begin
                    col  = int'(key[r]) % COLUMNS;
                    cval = cells[r][col];
                    mag  = cell_magnitude(cval);
                    if (mag < best) begin
                        best  = mag;
                        found = cval;
                    end else if (cval > 0) begin
                        // exact cell no smaller than the minimum: stop here
                        found = cval;
                        break;
                    end
                end
                ans.query_result = found[RESULT_W-1:0];
            end
            awaited_answers.push_back(ans);
        endfunction

        function void compare_answer(input logic [M_TDATA_W-1:0] data);
            sketch_answer_t             want;
            logic signed [RESULT_W-1:0] got_result;
            logic                       got_fresh;
            got_result = data[RESULT_W-1:0];
            got_fresh  = data[RESULT_W];
            if (awaited_answers.size() == 0) begin
                $error("result with no request pending: m_tdata=%h", data);
                mismatch_count++;
                return;
            end
            want = awaited_answers.pop_front();
            if (got_result !== want.query_result) begin
                $error("query_result: expected %0d, got %0d", want.query_result, got_result);
                mismatch_count++;
            end
            if (got_fresh !== want.insert_fresh) begin
                $error("insert_fresh: expected %0d, got %0d", want.insert_fresh, got_fresh);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    sketch_mirror sketch;
    bit           calm_phase = 1'b0;   // no idling on either side while set
    sketch_key_t  key_pool [POOL_SIZE];

    always #10 aclk = ~aclk;

    max_covering_sketch_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (calm_phase || pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Favor a few hot columns so that keys collide; keep the full range too.
    function automatic logic [IDX_W-1:0] pick_column();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return IDX_W'($urandom_range(0, 7));
        if (pick < 60) return IDX_W'($urandom_range(COLUMNS - 8, COLUMNS - 1));
        return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    endfunction

    function automatic sketch_key_t fresh_key();
        sketch_key_t key;
        for (int r = 0; r < MAX_ROWS; r++) key[r] = pick_column();
        return key;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_count();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 20) return '1;
        if (pick < 60) return VALUE_W'($urandom_range(1, 64));
        return VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
    endfunction

    function automatic sketch_key_t make_key(input int i0, input int i1,
                                             input int i2, input int i3);
        sketch_key_t key;
        key[0] = IDX_W'(i0);
        key[1] = IDX_W'(i1);
        key[2] = IDX_W'(i2);
        key[3] = IDX_W'(i3);
        return key;
    endfunction

    // Present one request, hold it until accepted, note it, then idle for a random gap that may be none.
    task automatic send_request(input req_type_t kind, input sketch_key_t key,
                                input logic [VALUE_W-1:0] value);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {value, key};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sketch.apply_request(kind, key, value);
        gap = idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Check every result at the edge that accepts it.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            sketch.compare_answer(m_tdata);
        end
    end

    // Result side: ready in runs, broken by random stalls.
    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            stall = idle_length();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin
        req_type_t   kind;
        sketch_key_t key;
        sketch = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= REQ_INSERT;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty store, extremes, zero inserts, flagging, early stop.
        send_request(REQ_QUERY,  make_key(0, 0, 0, 0), '0);
        send_request(REQ_INSERT, make_key(0, 0, 0, 0), '1);       // largest count
        send_request(REQ_QUERY,  make_key(0, 0, 0, 0), '0);
        send_request(REQ_INSERT, make_key(0, 0, 0, 0), 16'd100);  // smaller: flag
        send_request(REQ_QUERY,  make_key(0, 0, 0, 0), '1);       // count ignored
        send_request(REQ_INSERT, make_key(1023, 1023, 1023, 1023), '0);  // zero stays empty
        send_request(REQ_QUERY,  make_key(1023, 1023, 1023, 1023), '0);
        send_request(REQ_INSERT, make_key(1023, 1023, 1023, 1023), 16'd5);
        send_request(REQ_INSERT, make_key(1023, 1023, 1023, 1023), 16'd9); // larger: flag
        send_request(REQ_QUERY,  make_key(1023, 1023, 1023, 1023), '0);
        send_request(REQ_INSERT, make_key(0, 1023, 5, 6), 16'd7);
        send_request(REQ_QUERY,  make_key(0, 1023, 5, 6), '0);    // stop at last exact row
        send_request(REQ_INSERT, make_key(5, 6, 7, 8), 16'd3);
        send_request(REQ_QUERY,  make_key(5, 6, 1023, 0), '0);    // stop before flagged rows
        send_request(REQ_INSERT, make_key(5, 6, 7, 8), '0);       // zero flags positive cells
        send_request(REQ_QUERY,  make_key(5, 6, 7, 8), '0);
        send_request(REQ_INSERT, make_key(341, 682, 341, 682), 16'h5555);
        send_request(REQ_INSERT, make_key(682, 341, 682, 341), 16'hAAAA);
        send_request(REQ_QUERY,  make_key(341, 682, 341, 682), 16'hFFFF);
        send_request(REQ_QUERY,  make_key(682, 341, 682, 341), '0);
        send_request(REQ_INSERT, make_key(9, 10, 11, 12), 16'd1);
        send_request(REQ_QUERY,  make_key(9, 10, 11, 12), '0);

        // Random: mostly repeat keys from a pool, the rest fresh keys.
        foreach (key_pool[i]) key_pool[i] = fresh_key();
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            calm_phase = ((n / 100) % 5 == 4);
            if ($urandom_range(0, 99) < 5) key_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_key();
            if ($urandom_range(0, 99) < 70) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else key = fresh_key();
            kind = ($urandom_range(0, 1) == 1) ? REQ_QUERY : REQ_INSERT;
            send_request(kind, key, pick_count());
        end
        calm_phase = 1'b0;
        s_tvalid <= 1'b0;

        // Drain: wait for every pending answer, then a few spare cycles.
        while (sketch.awaited_answers.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sketch.mismatch_count == 0 && sketch.awaited_answers.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: 20 ms, several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
